// ----- src/mss_pkg.sv -----
// Shared types and constants for the Morse segment sequencer.
`default_nettype none

package mss_pkg;

    localparam int KIND_BITS = 3;
    localparam int STEP_BITS = 3;
    localparam int POS_BITS  = 3;
    localparam int PAT_BITS  = 6;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_DIT   = 3'd0,
        KIND_DAH   = 3'd1,
        KIND_INTRA = 3'd2,
        KIND_INTER = 3'd3,
        KIND_WORD  = 3'd4
    } t_kind;

    typedef enum logic {
        UNIT_CHAR    = 1'b0,
        UNIT_SPACING = 1'b1
    } t_unit_sel;

    typedef enum logic [1:0] {
        MUL_X1 = 2'd0,
        MUL_X3 = 2'd1,
        MUL_X5 = 2'd2
    } t_mult;

    typedef struct packed {
        logic                is_word;
        logic [POS_BITS-1:0] len;
        logic [PAT_BITS-1:0] pat;
    } t_code;

    typedef struct packed {
        logic      load;
        t_kind     kind;
        t_unit_sel unit_sel;
        t_mult     mult;
        logic      last;
    } t_emit;

endpackage

`default_nettype wire

// ----- src/mss_text_if.sv -----
// Input channel: one text byte per beat.
`default_nettype none

interface mss_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;

    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

`default_nettype wire

// ----- src/mss_seg_if.sv -----
// Output channel: one keying segment per beat.
`default_nettype none

interface mss_seg_if #(
    parameter int DUR_BITS = 19
);
    logic                          valid;
    logic                          ready;
    logic [mss_pkg::KIND_BITS-1:0] segment_kind;
    logic [DUR_BITS-1:0]           duration_samples;
    logic                          last_of_run;

    modport source (output valid, output segment_kind, output duration_samples,
                    output last_of_run, input ready);
    modport sink (input valid, input segment_kind, input duration_samples,
                  input last_of_run, output ready);
endinterface

`default_nettype wire

// ----- src/mss_cfg_regs.sv -----
// APB register file for the character and spacing unit lengths.
`default_nettype none

module mss_cfg_regs #(
    parameter int UNIT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    output logic      [31:0]          prdata,
    output logic                      pready,
    output logic      [UNIT_BITS-1:0] o_char_unit,
    output logic      [UNIT_BITS-1:0] o_spacing_unit
);

    localparam logic [31:0] UNIT_RESET = 32'd7350;

    logic [UNIT_BITS-1:0] r_char_unit;
    logic [UNIT_BITS-1:0] r_spacing_unit;
    logic [UNIT_BITS-1:0] n_wval;
    logic                 wr_en;
    logic [31:0]          wdata_lo;

    assign pready   = 1'b1;
    assign wr_en    = psel && penable && pwrite && pready;
    assign wdata_lo = {16'd0, pwdata[15:0]};
    assign n_wval   = wdata_lo[UNIT_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_unit    <= UNIT_RESET[UNIT_BITS-1:0];
            r_spacing_unit <= UNIT_RESET[UNIT_BITS-1:0];
        end else if (wr_en) begin
            if (paddr[2]) begin
                r_spacing_unit <= n_wval;
            end else begin
                r_char_unit <= n_wval;
            end
        end
    end

    always_comb begin
        if (paddr[2]) begin
            prdata = 32'(r_spacing_unit);
        end else begin
            prdata = 32'(r_char_unit);
        end
    end

    assign o_char_unit    = r_char_unit;
    assign o_spacing_unit = r_spacing_unit;

endmodule

`default_nettype wire

// ----- src/mss_code_lut.sv -----
// Morse code table: text byte to symbol pattern, length and word-gap flag.
`default_nettype none

module mss_code_lut (
    input  wire logic [7:0]    i_byte,
    output mss_pkg::t_code     o_code
);

    // {len, pattern}; pattern bit i set means symbol i is a dah
    localparam logic [8:0] LETTERS [26] = '{
        {3'd2, 6'b000010}, {3'd4, 6'b000001}, {3'd4, 6'b000101}, {3'd3, 6'b000001},
        {3'd1, 6'b000000}, {3'd4, 6'b000100}, {3'd3, 6'b000011}, {3'd4, 6'b000000},
        {3'd2, 6'b000000}, {3'd4, 6'b001110}, {3'd3, 6'b000101}, {3'd4, 6'b000010},
        {3'd2, 6'b000011}, {3'd2, 6'b000001}, {3'd3, 6'b000111}, {3'd4, 6'b000110},
        {3'd4, 6'b001011}, {3'd3, 6'b000010}, {3'd3, 6'b000000}, {3'd1, 6'b000001},
        {3'd3, 6'b000100}, {3'd4, 6'b001000}, {3'd3, 6'b000110}, {3'd4, 6'b001001},
        {3'd4, 6'b001101}, {3'd4, 6'b000011}
    };

    localparam logic [5:0] DIGITS [10] = '{
        6'b011111, 6'b011110, 6'b011100, 6'b011000, 6'b010000,
        6'b000000, 6'b000001, 6'b000011, 6'b000111, 6'b001111
    };

    logic [7:0] upper_off;
    logic [7:0] lower_off;
    logic [7:0] digit_off;

    assign upper_off = i_byte - 8'd65;
    assign lower_off = i_byte - 8'd97;
    assign digit_off = i_byte - 8'd48;

    always_comb begin
        o_code = '0;
        priority if (i_byte >= 8'd65 && i_byte <= 8'd90) begin
            o_code.len = LETTERS[upper_off[4:0]][8:6];
            o_code.pat = LETTERS[upper_off[4:0]][5:0];
        end else if (i_byte >= 8'd97 && i_byte <= 8'd122) begin
            o_code.len = LETTERS[lower_off[4:0]][8:6];
            o_code.pat = LETTERS[lower_off[4:0]][5:0];
        end else if (i_byte >= 8'd48 && i_byte <= 8'd57) begin
            o_code.len = 3'd5;
            o_code.pat = DIGITS[digit_off[3:0]];
        end else if (i_byte == 8'd44) begin
            o_code.len = 3'd6;
            o_code.pat = 6'b110011;
        end else if (i_byte == 8'd46) begin
            o_code.len = 3'd6;
            o_code.pat = 6'b101010;
        end else if (i_byte == 8'd61) begin
            o_code.len = 3'd5;
            o_code.pat = 6'b010001;
        end else if (i_byte == 8'd63) begin
            o_code.len = 3'd6;
            o_code.pat = 6'b001100;
        end else if (i_byte == 8'd32 || i_byte == 8'd10 || i_byte == 8'd7) begin
            o_code.is_word = 1'b1;
            o_code.len     = 3'd1;
        end else begin
            o_code = '0;
        end
    end

endmodule

`default_nettype wire

// ----- src/mss_seq.sv -----
// Microprogram sequencer: step counter, control ROM and conditional jumps.
`default_nettype none

module mss_seq (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire mss_pkg::t_code i_code,
    input  wire logic           i_out_free,
    output mss_pkg::t_emit      o_emit
);

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_SEEN,
        COND_NO_SYMS,
        COND_WORD,
        COND_LAST_SYM
    } t_cond;

    typedef logic [mss_pkg::STEP_BITS-1:0] t_step;

    typedef struct packed {
        logic               wait_in;
        t_cond              emit;
        mss_pkg::t_kind     kind;
        logic               kind_from_sym;
        mss_pkg::t_unit_sel unit_sel;
        mss_pkg::t_mult     mult;
        t_cond              last;
        t_cond              jump;
        t_step              target;
        logic               pos_inc;
    } t_uword;

    localparam t_step STEP_FETCH = 3'd0;
    localparam t_step STEP_INTER = 3'd1;
    localparam t_step STEP_SPLIT = 3'd2;
    localparam t_step STEP_SYM   = 3'd3;
    localparam t_step STEP_INTRA = 3'd4;
    localparam t_step STEP_WORD  = 3'd5;

    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w = '{wait_in: 1'b0, emit: COND_NEVER, kind: mss_pkg::KIND_DIT,
              kind_from_sym: 1'b0, unit_sel: mss_pkg::UNIT_CHAR,
              mult: mss_pkg::MUL_X1, last: COND_NEVER, jump: COND_NEVER,
              target: STEP_FETCH, pos_inc: 1'b0};
        unique case (step)
            STEP_FETCH: begin
                w.wait_in = 1'b1;
            end
            STEP_INTER: begin
                w.emit     = COND_SEEN;
                w.kind     = mss_pkg::KIND_INTER;
                w.unit_sel = mss_pkg::UNIT_SPACING;
                w.mult     = mss_pkg::MUL_X3;
                w.last     = COND_NO_SYMS;
                w.jump     = COND_NO_SYMS;
                w.target   = STEP_FETCH;
            end
            STEP_SPLIT: begin
                w.jump   = COND_WORD;
                w.target = STEP_WORD;
            end
            STEP_SYM: begin
                w.emit          = COND_ALWAYS;
                w.kind_from_sym = 1'b1;
                w.last          = COND_LAST_SYM;
                w.jump          = COND_LAST_SYM;
                w.target        = STEP_FETCH;
            end
            STEP_INTRA: begin
                w.emit    = COND_ALWAYS;
                w.kind    = mss_pkg::KIND_INTRA;
                w.pos_inc = 1'b1;
                w.jump    = COND_ALWAYS;
                w.target  = STEP_SYM;
            end
            STEP_WORD: begin
                w.emit     = COND_ALWAYS;
                w.kind     = mss_pkg::KIND_WORD;
                w.unit_sel = mss_pkg::UNIT_SPACING;
                w.mult     = mss_pkg::MUL_X5;
                w.last     = COND_ALWAYS;
                w.jump     = COND_ALWAYS;
                w.target   = STEP_FETCH;
            end
            default: begin
                w.jump   = COND_ALWAYS;
                w.target = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

    t_step                         r_step;
    t_step                         n_step;
    logic [mss_pkg::POS_BITS-1:0]  r_pos;
    logic [mss_pkg::POS_BITS-1:0]  n_pos;
    mss_pkg::t_code                r_code;
    logic                          r_seen;
    logic                          r_prev_seen;
    t_uword                        uw;
    logic                          no_syms;
    logic                          last_sym;
    logic                          sym_dah;
    logic                          accept;
    logic                          emit_want;
    logic                          advance;
    logic                          take_jump;

    function automatic logic eval(input t_cond c, input logic seen, input logic nsym,
                                  input logic word, input logic lsym);
        logic r;
        unique case (c)
            COND_NEVER:    r = 1'b0;
            COND_ALWAYS:   r = 1'b1;
            COND_SEEN:     r = seen;
            COND_NO_SYMS:  r = nsym;
            COND_WORD:     r = word;
            COND_LAST_SYM: r = lsym;
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

    assign uw       = ucode(r_step);
    assign no_syms  = !r_code.is_word && (r_code.len == '0);
    assign last_sym = (r_pos == (r_code.len - 3'd1));
    assign sym_dah  = r_code.pat[r_pos];

    assign o_in_ready = uw.wait_in;
    assign accept     = uw.wait_in && i_in_valid;
    assign emit_want  = eval(uw.emit, r_prev_seen, no_syms, r_code.is_word, last_sym);
    assign advance    = uw.wait_in ? accept : !(emit_want && !i_out_free);
    assign take_jump  = eval(uw.jump, r_prev_seen, no_syms, r_code.is_word, last_sym);

    always_comb begin
        o_emit.load     = emit_want && i_out_free && !uw.wait_in;
        o_emit.unit_sel = uw.unit_sel;
        o_emit.last     = eval(uw.last, r_prev_seen, no_syms, r_code.is_word, last_sym);
        if (uw.kind_from_sym) begin
            o_emit.kind = sym_dah ? mss_pkg::KIND_DAH : mss_pkg::KIND_DIT;
            o_emit.mult = sym_dah ? mss_pkg::MUL_X3 : mss_pkg::MUL_X1;
        end else begin
            o_emit.kind = uw.kind;
            o_emit.mult = uw.mult;
        end
    end

    always_comb begin
        n_step = r_step;
        n_pos  = r_pos;
        if (advance) begin
            n_step = take_jump ? uw.target : r_step + 3'd1;
            if (accept) begin
                n_pos = '0;
            end else if (uw.pos_inc) begin
                n_pos = r_pos + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_FETCH;
            r_pos       <= '0;
            r_seen      <= 1'b0;
            r_prev_seen <= 1'b0;
        end else begin
            r_step <= n_step;
            r_pos  <= n_pos;
            if (accept) begin
                r_prev_seen <= r_seen;
                r_seen      <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_code <= i_code;
        end
    end

endmodule

`default_nettype wire

// ----- src/mss_dpath.sv -----
// Duration datapath and output register for segment beats.
`default_nettype none

module mss_dpath #(
    parameter int UNIT_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [UNIT_BITS-1:0] i_char_unit,
    input  wire logic [UNIT_BITS-1:0] i_spacing_unit,
    input  wire mss_pkg::t_emit       i_emit,
    output logic                      o_free,
    mss_seg_if.source                 o_seg
);

    localparam int DUR_BITS = UNIT_BITS + 3;

    logic [DUR_BITS-1:0]          unit_x;
    logic [DUR_BITS-1:0]          n_dur;
    logic [DUR_BITS-1:0]          r_dur;
    logic [mss_pkg::KIND_BITS-1:0] r_kind;
    logic                         r_last;
    logic                         r_valid;

    assign unit_x = (i_emit.unit_sel == mss_pkg::UNIT_SPACING) ?
                    DUR_BITS'(i_spacing_unit) : DUR_BITS'(i_char_unit);

    always_comb begin
        unique case (i_emit.mult)
            mss_pkg::MUL_X1: n_dur = unit_x;
            mss_pkg::MUL_X3: n_dur = (unit_x << 1) + unit_x;
            mss_pkg::MUL_X5: n_dur = (unit_x << 2) + unit_x;
            default:         n_dur = unit_x;
        endcase
    end

    assign o_free = !r_valid || o_seg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_emit.load) begin
            r_valid <= 1'b1;
        end else if (o_seg.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_emit.load) begin
            r_dur  <= n_dur;
            r_kind <= i_emit.kind;
            r_last <= i_emit.last;
        end
    end

    assign o_seg.valid            = r_valid;
    assign o_seg.segment_kind     = r_kind;
    assign o_seg.duration_samples = r_dur;
    assign o_seg.last_of_run      = r_last;

endmodule

`default_nettype wire

// ----- src/morse_segment_sequencer_unit.sv -----
// Top level of the Morse segment sequencer.
//
// i_text takes one text byte per beat; o_seg gives one keying segment per
// beat (kind, length in samples, last-of-run flag). Every byte after the
// first opens with an inter-character gap; letters, digits and , . = ?
// give dits, dahs and intra-character gaps; space, line feed and code 7
// give a word gap; other bytes give nothing beyond the opening gap.
// A byte is taken only when the control program sits at its fetch step.
// The opening gap is loaded into the output register at the inter-character
// step after fetch; the first byte, which has no opening gap, shows its first
// segment after the fetch, inter-character and branch steps. Then, while
// o_seg does not stall, one segment per cycle follows; besides its segments a
// byte spends the fetch and branch steps (an unmapped byte only fetch).
// The microprogram step counter and single output register set that pace.
// A stall on o_seg holds the step counter and the registered segment.
// Reset clears the first-byte flag, returns the program to fetch and
// loads 7350 into both unit registers (APB offsets 0 and 4).
`default_nettype none

module morse_segment_sequencer_unit #(
    parameter int UNIT_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    mss_text_if.sink         i_text,
    mss_seg_if.source        o_seg,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [UNIT_BITS-1:0] char_unit;
    logic [UNIT_BITS-1:0] spacing_unit;
    mss_pkg::t_code       code;
    mss_pkg::t_emit       emit;
    logic                 out_free;

    mss_cfg_regs #(
        .UNIT_BITS(UNIT_BITS)
    ) u_cfg (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .o_char_unit    (char_unit),
        .o_spacing_unit (spacing_unit)
    );

    mss_code_lut u_lut (
        .i_byte (i_text.text_byte),
        .o_code (code)
    );

    mss_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_text.valid),
        .o_in_ready (i_text.ready),
        .i_code     (code),
        .i_out_free (out_free),
        .o_emit     (emit)
    );

    mss_dpath #(
        .UNIT_BITS(UNIT_BITS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_char_unit    (char_unit),
        .i_spacing_unit (spacing_unit),
        .i_emit         (emit),
        .o_free         (out_free),
        .o_seg          (o_seg)
    );

endmodule

`default_nettype wire
